// ----- hw/rtl/bss_pkg.sv -----
package bss_pkg;

   localparam int BYTE_W      = 8;
   localparam int STATUS_W    = 3;
   localparam int POS_W       = 16;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 24;

   typedef enum logic {
      OP_PATTERN  = 1'b0,
      OP_HAYSTACK = 1'b1
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_NOT_FOUND = 3'd0,
      ST_FOUND     = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_PAT_LONG  = 3'd3,
      ST_HAY_LONG  = 3'd4
   } status_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic              shift;
      logic              clear;
      logic [BYTE_W-1:0] data_byte;
   } cell_ctrl_type;

   typedef struct packed {
      status_type       status;
      logic [POS_W-1:0] position;
   } rsp_type;

endpackage

// ----- hw/rtl/byte_substring_search.sv -----
// Streaming leftmost byte-pattern search.
// Request channel (req_): one byte per transfer. req_tuser selects the kind:
// pattern byte (appended to the pattern) or haystack byte. req_tlast marks
// the final haystack byte of a search. The first pattern byte after reset or
// after a finished search starts a new pattern; a pattern byte in the middle
// of a search aborts it without a result.
// Response channel (rsp_): at most one transfer per search, either found with
// the start offset (on the byte that completes the first match) or a status
// on the last haystack byte.
// Throughput: one request per cycle while req_tready is high. A row of
// PATTERN_MAX cells, each holding one pattern byte and a prefix-match flag
// handed to its right neighbour, compares every haystack byte in parallel.
// Response path: each response is registered in the output buffer first.
// Stall: an output register plus a skid stage hold up to two responses;
// req_tready drops only while both are occupied.
// Reset: synchronous, clears pattern length, match flags, counters and the
// output buffer; pattern bytes themselves are not cleared.
module byte_substring_search import bss_pkg::*; #(
   parameter int                PATTERN_MAX  = 16,
   parameter longint unsigned   HAYSTACK_MAX = 65536
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [7:0] data_byte
   input  logic                   req_tuser,   // [0] opcode
   input  logic                   req_tlast,   // last haystack byte
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata    // [2:0] status, [18:3] position
);

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);
   localparam int CNT_W = $clog2(HAYSTACK_MAX + 2);
   localparam int DIF_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam logic [CNT_W-1:0] HAY_MAX_C = CNT_W'(HAYSTACK_MAX);
   localparam logic [LEN_W-1:0] PAT_MAX_C = LEN_W'(PATTERN_MAX);

   logic [LEN_W-1:0] len_ff, len_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             given_ff, given_in;
   logic             start_new_ff, start_new_in;

   logic             acc, is_pat, is_hay;
   logic [LEN_W-1:0] eff_len;
   logic [CNT_W-1:0] count_inc;
   logic [DIF_W-1:0] diff;
   logic             in_range;
   logic             found;
   logic             push;
   logic             can_accept;
   rsp_type          push_data;
   rsp_type          rsp_data;
   cell_ctrl_type    ctrl;

   logic [PATTERN_MAX-1:0] wr_en;
   logic [PATTERN_MAX-1:0] hit;
   logic [PATTERN_MAX-1:0] sel_hit;
   logic [PATTERN_MAX-1:0] match_ff;

   assign req_tready = can_accept;
   assign acc        = req_tvalid && req_tready;
   assign is_pat     = acc && (opcode_type'(req_tuser) == OP_PATTERN);
   assign is_hay     = acc && (opcode_type'(req_tuser) == OP_HAYSTACK);

   // a new pattern restarts at offset zero
   assign eff_len = start_new_ff ? '0 : len_ff;

   // broadcast: shift on every haystack byte, drop all flags on a pattern
   // byte or at the end of a search
   assign ctrl.shift     = is_hay;
   assign ctrl.clear     = is_pat || (is_hay && req_tlast);
   assign ctrl.data_byte = req_tdata[BYTE_W-1:0];

   for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
      logic prev;
      if (j == 0) begin : g_head
         assign prev = 1'b1;
      end else begin : g_link
         assign prev = match_ff[j-1];
      end

      assign wr_en[j]   = is_pat && (eff_len == LEN_W'(j));
      assign sel_hit[j] = hit[j] && (len_ff == LEN_W'(j + 1));

      bss_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .wr_en      (wr_en[j]),
         .prev_match (prev),
         .hit        (hit[j]),
         .match_ff   (match_ff[j])
      );
   end

   // saturate the count one above the limit
   assign count_inc = (count_ff <= HAY_MAX_C) ? count_ff + 1'b1 : count_ff;
   assign in_range  = count_ff < HAY_MAX_C;
   assign diff      = DIF_W'(count_inc) - DIF_W'(len_ff);

   assign found = is_hay && !given_ff && (len_ff != '0) && !ovf_ff && in_range
                  && (|sel_hit);
   assign push  = found || (is_hay && req_tlast && !given_ff);

   always_comb begin
      push_data.position = '0;
      if (found) begin
         push_data.status   = ST_FOUND;
         push_data.position = diff[POS_W-1:0];
      end else if (len_ff == '0) begin
         push_data.status = ST_EMPTY;
      end else if (ovf_ff) begin
         push_data.status = ST_PAT_LONG;
      end else if (!in_range) begin
         push_data.status = ST_HAY_LONG;
      end else begin
         push_data.status = ST_NOT_FOUND;
      end
   end

   always_comb begin
      len_in       = len_ff;
      ovf_in       = ovf_ff;
      count_in     = count_ff;
      given_in     = given_ff;
      start_new_in = start_new_ff;
      if (is_pat) begin
         count_in     = '0;
         given_in     = 1'b0;
         start_new_in = 1'b0;
         ovf_in       = start_new_ff ? 1'b0 : ovf_ff;
         if (eff_len < PAT_MAX_C) begin
            len_in = eff_len + 1'b1;
         end else begin
            len_in = eff_len;
            ovf_in = 1'b1;
         end
      end else if (is_hay) begin
         if (req_tlast) begin
            count_in     = '0;
            given_in     = 1'b0;
            start_new_in = 1'b1;
         end else begin
            count_in = count_inc;
            given_in = given_ff || found;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         count_ff     <= '0;
         given_ff     <= 1'b0;
         start_new_ff <= 1'b1;
      end else begin
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         count_ff     <= count_in;
         given_ff     <= given_in;
         start_new_ff <= start_new_in;
      end
   end

   bss_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .can_accept (can_accept),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data)
   );

   assign rsp_tdata = {{(RSP_TDATA_W - POS_W - STATUS_W){1'b0}},
                       rsp_data.position, rsp_data.status};

   // a found result needs a valid, non-overflowed pattern
   a_given_pattern: assert property (@(posedge clock) disable iff (reset)
      given_ff |-> (len_ff != '0) && !ovf_ff)
      else $error("result flag set without a usable pattern");

   // the haystack count never passes its saturation point
   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      count_ff <= HAY_MAX_C + 1'b1)
      else $error("haystack count beyond saturation");

   // back-pressure only while a response is pending
   a_stall_pending: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("request stalled with no pending response");

   // a second found result within one search must not happen
   a_single_found: assert property (@(posedge clock) disable iff (reset)
      (found && !req_tlast) |=> !found)
      else $error("second match reported in one search");

endmodule

// ----- hw/rtl/bss_cell.sv -----
module bss_cell import bss_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic          wr_en,
   input  logic          prev_match,
   output logic          hit,
   output logic          match_ff
);

   logic [BYTE_W-1:0] pat_ff;
   logic [BYTE_W-1:0] pat_in;
   logic              match_in;

   // prefix up to this cell ends on the current byte
   assign hit = prev_match && (ctrl.data_byte == pat_ff);

   always_comb begin
      pat_in   = wr_en ? ctrl.data_byte : pat_ff;
      match_in = match_ff;
      if (ctrl.clear) begin
         match_in = 1'b0;
      end else if (ctrl.shift) begin
         match_in = hit;
      end
   end

   always_ff @(posedge clock) begin
      pat_ff <= pat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

endmodule

// ----- hw/rtl/bss_out_buf.sv -----
module bss_out_buf import bss_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    can_accept,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output rsp_type rsp_data
);

   logic    out_valid_ff;
   logic    out_valid_in;
   logic    skid_valid_ff;
   logic    skid_valid_in;
   rsp_type out_data_ff;
   rsp_type out_data_in;
   rsp_type skid_data_ff;
   rsp_type skid_data_in;
   logic    pop;

   assign pop        = out_valid_ff && rsp_tready;
   assign can_accept = !skid_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_data   = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // no push possible here: refill from the skid stage
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_valid_in = 1'b1;
            out_data_in  = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = push_data;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

endmodule
